[rtl/aeic_pkg.sv]
// Shared types and constants for the acyclic edge insert checker.
// No dependencies; used by aeic_search and the top level.
`timescale 1ns / 1ps

package aeic_pkg;

  // width of a vertex number on the item channels
  localparam int VTX_W = 5;
  // width of the vertex count register
  localparam int CNT_W = 6;

  // item kinds
  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_ADD   = 1'b1;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } aeic_state_t;

  // command to the search unit
  typedef struct packed {
    logic             start;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
  } aeic_search_cmd_t;

  // status back from the search unit
  typedef struct packed {
    logic done;
    logic hit;
  } aeic_search_sts_t;

endpackage

[rtl/aeic_matrix.sv]
// Adjacency bit matrix: one row per vertex, cleared at reset.
// One combinational row read port and one single-bit set port.
`timescale 1ns / 1ps

module aeic_matrix #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_idx,
  output logic [MAX_VERTICES-1:0]         rd_row,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_VERTICES)-1:0] wr_row,
  input  logic [$clog2(MAX_VERTICES)-1:0] wr_col
);

  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];

  // set one edge bit; reset clears the whole graph
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows[i] <= '0;
      end
    end else if (wr_en) begin
      rows[wr_row][wr_col] <= 1'b1;
    end
  end

  // row read for the search unit
  assign rd_row = rows[rd_idx];

endmodule

[rtl/aeic_search.sv]
// Iterative reachability search: one vertex of the frontier expanded per cycle.
// Depends on aeic_pkg; reads rows from aeic_matrix through rd_idx / rd_row.
`timescale 1ns / 1ps

module aeic_search #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  aeic_pkg::aeic_search_cmd_t      cmd,
  input  logic [MAX_VERTICES-1:0]         mask,
  output logic [$clog2(MAX_VERTICES)-1:0] rd_idx,
  input  logic [MAX_VERTICES-1:0]         rd_row,
  output aeic_pkg::aeic_search_sts_t      sts
);

  localparam int IDX_W = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] frontier;
  logic [MAX_VERTICES-1:0] visited;
  logic [IDX_W-1:0]        dst_idx;
  logic                    busy;

  logic [MAX_VERTICES-1:0] lowest;
  logic [MAX_VERTICES-1:0] row_m;
  logic [MAX_VERTICES-1:0] new_bits;
  logic                    empty;
  logic                    hit;

  // pick the lowest pending vertex
  assign lowest = frontier & (~frontier + 1'b1);

  always_comb begin
    rd_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (lowest[i]) begin
        rd_idx = rd_idx | IDX_W'(i);
      end
    end
  end

  // expand its row, ignoring vertices outside the active count
  assign row_m    = rd_row & mask;
  assign new_bits = row_m & ~visited;
  assign empty    = (frontier == '0);
  assign hit      = row_m[dst_idx];

  always_comb begin
    sts.done = busy & (empty | hit);
    sts.hit  = busy & ~empty & hit;
  end

  // busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (sts.done) begin
      busy <= 1'b0;
    end
  end

  // frontier and visited sets
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      frontier <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << cmd.src;
      visited  <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << cmd.src;
      dst_idx  <= IDX_W'(cmd.dst);
    end else if (busy && !empty && !hit) begin
      frontier <= (frontier & ~lowest) | new_bits;
      visited  <= visited | new_bits;
    end
  end

endmodule

[rtl/acyclic_edge_insert_checker.sv]
// Top level of the acyclic edge insert checker: sequencer, output register,
// count register. Depends on aeic_pkg, aeic_matrix and aeic_search.
`timescale 1ns / 1ps

// Keeps a directed dependency graph as a bit matrix and answers one item at a
// time. Input channel s_*: tuser is the kind (query or add), tdata holds the
// two vertex numbers. Output channel m_*: tdata bit 0 is the answer, tuser is
// the out-of-range flag. cfg_* writes the vertex count and is always ready;
// the user must write it only while the block is idle (not enforced).
// A query asks whether vertex a reaches b; an add stores edge (a,b) unless b
// already reaches a. The search expands one frontier vertex per cycle through
// a single row read port of the matrix; out-of-range items and items with a
// equal to b skip the search and go straight to the done state.
// One item is processed at a time: s_tready is high only while idle. A
// finished result sits in the output register; the next item may be accepted
// meanwhile, and its result waits in the done state until m_tready frees the
// register.
// Reset clears the graph, sets the vertex count to 32 and empties the output.

module acyclic_edge_insert_checker #(
  parameter int MAX_VERTICES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // vertex count write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // request items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] vertex_a, [9:5] vertex_b, rest zero
  input  logic [0:0]  s_tuser,   // [0] kind
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] answer, rest zero
  output logic [0:0]  m_tuser    // [0] out_of_range
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int VW    = aeic_pkg::VTX_W;
  localparam int CW    = aeic_pkg::CNT_W;

  aeic_pkg::aeic_state_t state, state_next;

  logic [CW-1:0]           vertex_count;
  logic                    kind_q;
  logic [VW-1:0]           a_q;
  logic [VW-1:0]           b_q;
  logic                    oor_q;
  logic                    same_q;
  logic                    hit_q;
  logic                    answer_q;
  logic                    oor_out;

  logic                    accept;
  logic [VW-1:0]           in_a;
  logic [VW-1:0]           in_b;
  logic                    in_oor;
  logic                    out_free;
  logic                    load_out;
  logic                    stored;
  logic                    answer_next;
  logic [MAX_VERTICES-1:0] mask;
  logic [IDX_W-1:0]        rd_idx;
  logic [MAX_VERTICES-1:0] rd_row;
  logic                    wr_en;

  aeic_pkg::aeic_search_cmd_t cmd;
  aeic_pkg::aeic_search_sts_t sts;

  // vertex count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CW'(32);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // active vertex mask and range check
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (7'(i) < {1'b0, vertex_count});
    end
  end

  assign in_a   = s_tdata[VW-1:0];
  assign in_b   = s_tdata[2*VW-1:VW];
  assign in_oor = ({1'b0, in_a} >= vertex_count) || ({1'b0, in_b} >= vertex_count) ||
                  (7'(in_a) >= 7'(MAX_VERTICES)) || (7'(in_b) >= 7'(MAX_VERTICES));

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // result of the held item
  assign stored      = !oor_q && (same_q || !hit_q);
  assign answer_next = (kind_q == aeic_pkg::KIND_ADD) ? stored
                                                      : (!oor_q && !same_q && hit_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      aeic_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (in_oor || in_a == in_b) ? aeic_pkg::ST_DONE : aeic_pkg::ST_SEARCH;
        end
      end
      aeic_pkg::ST_SEARCH: begin
        if (sts.done) state_next = aeic_pkg::ST_DONE;
      end
      aeic_pkg::ST_DONE: begin
        if (out_free) state_next = aeic_pkg::ST_IDLE;
      end
      default: state_next = aeic_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = (state == aeic_pkg::ST_IDLE);
    cmd.start = accept && !in_oor && (in_a != in_b);
    cmd.src   = (s_tuser[0] == aeic_pkg::KIND_ADD) ? in_b : in_a;
    cmd.dst   = (s_tuser[0] == aeic_pkg::KIND_ADD) ? in_a : in_b;
    load_out  = (state == aeic_pkg::ST_DONE) && out_free;
    wr_en     = load_out && (kind_q == aeic_pkg::KIND_ADD) && stored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aeic_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // held item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= s_tuser[0];
      a_q    <= in_a;
      b_q    <= in_b;
      oor_q  <= in_oor;
      same_q <= (in_a == in_b);
      hit_q  <= 1'b0;
    end else if (sts.done) begin
      hit_q <= sts.hit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      answer_q <= answer_next;
      oor_out  <= oor_q;
    end
  end

  assign m_tdata = {7'b0, answer_q};
  assign m_tuser = oor_out;

  aeic_matrix #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_matrix (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd_row (rd_row),
    .wr_en  (wr_en),
    .wr_row (IDX_W'(a_q)),
    .wr_col (IDX_W'(b_q))
  );

  aeic_search #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .mask   (mask),
    .rd_idx (rd_idx),
    .rd_row (rd_row),
    .sts    (sts)
  );

  // search completes only while the sequencer waits for it
  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> state == aeic_pkg::ST_SEARCH)
    else $error("search finished outside the search state");

  // an out-of-range result never carries a positive answer
  a_oor_no_answer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tdata[0])
    else $error("out-of-range result with answer set");

  // a finished result waits while the output register is stalled
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    state == aeic_pkg::ST_DONE && m_tvalid && !m_tready |=> state == aeic_pkg::ST_DONE)
    else $error("result left done state over a stalled output");

  // the graph is only written when a result is loaded
  a_write_on_load: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> m_tvalid)
    else $error("edge stored without a result item");

endmodule
